// ===== hw/rtl/bbt_pkg.sv =====
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared types, constants and fixed-point helpers for the bounding-box
// placement transform.
// ----------------------------------------------------------------------------
package bbt_pkg;

  // Channel and configuration port widths
  localparam int IN_W       = 192;
  localparam int OUT_W      = 384;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 63;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_MODE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANSLATE_MODE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_XYZ      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANSLATE_XYZ  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ANGLES_XYZ     = 3'd4;

  // Scale modes
  localparam logic [2:0] SM_NONE   = 3'd0;
  localparam logic [2:0] SM_MIN    = 3'd1;
  localparam logic [2:0] SM_MAX    = 3'd2;
  localparam logic [2:0] SM_REL    = 3'd3;
  localparam logic [2:0] SM_EXTENT = 3'd4;

  // Translate modes
  localparam logic [1:0] TM_CENTER = 2'd0;
  localparam logic [1:0] TM_OFFSET = 2'd1;
  localparam logic [1:0] TM_ABS    = 2'd2;

  // Fixed point
  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh80000000;

  // Rotation matrix entries (Q16.16, magnitude below 8.0)
  localparam int ROT_W = 20;
  typedef logic signed [ROT_W-1:0] rot_ent_t;
  localparam rot_ent_t ROT_ONE = 20'sd65536;

  // Sine and cosine in Q16.16, clamped to [-1, 1]
  localparam int SC_W = 18;
  typedef logic signed [SC_W-1:0] trig_t;

  // CORDIC
  localparam int CORDIC_STEPS = 18;
  localparam int XY_W         = 34;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Divider: quotient magnitude bits after the overflow check, total latency
  localparam int DIV_QBITS = 31;
  localparam int DIV_LAT   = DIV_QBITS + 2;

  typedef enum logic [2:0] {
    ROT_IDLE,
    ROT_LOAD,
    ROT_ITER,
    ROT_STORE,
    ROT_MAC
  } rot_state_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [XY_W-1:0] atan_turn(input logic [4:0] i);
    logic signed [XY_W-1:0] v;
    case (i)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667342;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679839;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up from Q32.32-scaled product back to Q16.16
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    return (v + 66'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -66'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bbt_div.sv =====
// ----------------------------------------------------------------------------
// bbt_div
// Pipelined saturating Q16.16 divider: (num * 2^24) / den, one quotient bit
// per stage, truncated toward zero and clamped to 32 bits.
// ----------------------------------------------------------------------------
module bbt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [20:0] num,
  input  logic signed [32:0] den,
  output logic               out_valid,
  output logic signed [31:0] quo
);

  localparam int QB    = bbt_pkg::DIV_QBITS;
  localparam int REM_W = 45;

  logic               v_r   [QB+1];
  logic [REM_W-1:0]   rem_r [QB+1];
  logic [QB-1:0]      q_r   [QB+1];
  logic [32:0]        ad_r  [QB+1];
  logic               zf_r  [QB+1];
  logic               of_r  [QB+1];
  logic               ng_r  [QB+1];

  logic [REM_W-1:0]   rem_nxt [1:QB];
  logic [QB-1:0]      q_nxt   [1:QB];

  logic [20:0]        af;
  logic [32:0]        ad;
  logic               out_valid_r;
  logic signed [31:0] quo_r;
  logic signed [31:0] quo_nxt;

  assign af = num[20] ? 21'(-num) : 21'(num);
  assign ad = den[32] ? 33'(-den) : 33'(den);

  always_comb begin
    logic [63:0] cand;
    logic [63:0] remx;
    for (int j = 1; j <= QB; j++) begin
      cand = 64'(ad_r[j-1]) << (QB - j);
      remx = 64'(rem_r[j-1]);
      if (remx >= cand) begin
        rem_nxt[j] = REM_W'(remx - cand);
        q_nxt[j]   = q_r[j-1] | (QB'(1) << (QB - j));
      end else begin
        rem_nxt[j] = rem_r[j-1];
        q_nxt[j]   = q_r[j-1];
      end
    end
  end

  always_comb begin
    if (zf_r[QB]) begin
      quo_nxt = '0;
    end else if (of_r[QB]) begin
      quo_nxt = ng_r[QB] ? bbt_pkg::Q_MIN : bbt_pkg::Q_MAX;
    end else if (ng_r[QB]) begin
      quo_nxt = -$signed({1'b0, q_r[QB]});
    end else begin
      quo_nxt = $signed({1'b0, q_r[QB]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) begin
        v_r[j] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int j = 1; j <= QB; j++) begin
        v_r[j] <= v_r[j-1];
      end
      out_valid_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {af, 24'b0};
      q_r[0]   <= '0;
      ad_r[0]  <= ad;
      zf_r[0]  <= (af == '0);
      // quotient of 2^31 or more, and any nonzero over zero, saturates
      of_r[0]  <= (40'(af) >= {ad, 7'b0});
      ng_r[0]  <= num[20] ^ den[32];
      for (int j = 1; j <= QB; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        ad_r[j]  <= ad_r[j-1];
        zf_r[j]  <= zf_r[j-1];
        of_r[j]  <= of_r[j-1];
        ng_r[j]  <= ng_r[j-1];
      end
      quo_r <= quo_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign quo       = quo_r;

endmodule

// ===== hw/rtl/bbt_rot.sv =====
// ----------------------------------------------------------------------------
// bbt_rot
// Rotation setup: iterative CORDIC for the three angles, then the products
// (Rx * Ry) * Rz on one shared multiply-accumulate.
// ----------------------------------------------------------------------------
module bbt_rot (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [47:0]       angles,
  output logic              busy,
  output bbt_pkg::rot_ent_t rot_o [3][3]
);

  localparam logic [4:0] IT_LAST = 5'(bbt_pkg::CORDIC_STEPS - 1);

  bbt_pkg::rot_state_t state_r, state_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [4:0]  it_r, it_nxt;
  logic        ph_r, ph_nxt;
  logic [1:0]  r_r, r_nxt;
  logic [1:0]  c_r, c_nxt;
  logic [1:0]  k_r, k_nxt;
  logic        ld, step, st, mac;

  logic [47:0] ang_r;
  logic signed [bbt_pkg::XY_W-1:0] x_r, y_r, z_r;
  bbt_pkg::trig_t    cs_r [3];
  bbt_pkg::trig_t    sn_r [3];
  logic signed [41:0] acc_r;
  bbt_pkg::rot_ent_t rxy_r [3][3];
  bbt_pkg::rot_ent_t rot_r [3][3];

  logic [15:0] aw;
  logic signed [bbt_pkg::XY_W-1:0] dx, dy, xr, yr;
  bbt_pkg::trig_t cv, sv, cq, sq;
  bbt_pkg::rot_ent_t rxm [3][3];
  bbt_pkg::rot_ent_t rym [3][3];
  bbt_pkg::rot_ent_t rzm [3][3];
  bbt_pkg::rot_ent_t ma, mb, wv;
  logic signed [39:0] prod;
  logic signed [41:0] acc_sum;

  function automatic bbt_pkg::trig_t clamp_unit(input logic signed [bbt_pkg::XY_W-1:0] v);
    bbt_pkg::trig_t r;
    if (v > 34'sd65536) begin
      r = 18'sd65536;
    end else if (v < -34'sd65536) begin
      r = -18'sd65536;
    end else begin
      r = bbt_pkg::SC_W'(v);
    end
    return r;
  endfunction

  // FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbt_pkg::ROT_IDLE;
      axis_r  <= '0;
      it_r    <= '0;
      ph_r    <= 1'b0;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      it_r    <= it_nxt;
      ph_r    <= ph_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    it_nxt    = it_r;
    ph_nxt    = ph_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    ld        = 1'b0;
    step      = 1'b0;
    st        = 1'b0;
    mac       = 1'b0;
    case (state_r)
      bbt_pkg::ROT_IDLE: begin
        if (start) begin
          axis_nxt  = '0;
          state_nxt = bbt_pkg::ROT_LOAD;
        end
      end
      bbt_pkg::ROT_LOAD: begin
        ld        = 1'b1;
        it_nxt    = '0;
        state_nxt = bbt_pkg::ROT_ITER;
      end
      bbt_pkg::ROT_ITER: begin
        step = 1'b1;
        if (it_r == IT_LAST) begin
          state_nxt = bbt_pkg::ROT_STORE;
        end else begin
          it_nxt = it_r + 5'd1;
        end
      end
      bbt_pkg::ROT_STORE: begin
        st = 1'b1;
        if (axis_r == 2'd2) begin
          ph_nxt    = 1'b0;
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          state_nxt = bbt_pkg::ROT_MAC;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = bbt_pkg::ROT_LOAD;
        end
      end
      bbt_pkg::ROT_MAC: begin
        mac = 1'b1;
        if (k_r == 2'd2) begin
          k_nxt = '0;
          if (c_r == 2'd2) begin
            c_nxt = '0;
            if (r_r == 2'd2) begin
              r_nxt = '0;
              if (ph_r) begin
                state_nxt = bbt_pkg::ROT_IDLE;
              end else begin
                ph_nxt = 1'b1;
              end
            end else begin
              r_nxt = r_r + 2'd1;
            end
          end else begin
            c_nxt = c_r + 2'd1;
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      default: state_nxt = bbt_pkg::ROT_IDLE;
    endcase
  end

  // CORDIC datapath
  always_comb begin
    case (axis_r)
      2'd0:    aw = ang_r[15:0];
      2'd1:    aw = ang_r[31:16];
      default: aw = ang_r[47:32];
    endcase
  end

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign xr = (x_r + 34'sd8192) >>> 14;
  assign yr = (y_r + 34'sd8192) >>> 14;

  always_comb begin
    if (aw[13:0] == '0) begin
      cv = 18'sd65536;
      sv = '0;
    end else begin
      cv = clamp_unit(xr);
      sv = clamp_unit(yr);
    end
    // fold the quadrant back in
    case (aw[15:14])
      2'd0:    begin cq = cv;  sq = sv;  end
      2'd1:    begin cq = -sv; sq = cv;  end
      2'd2:    begin cq = -cv; sq = -sv; end
      default: begin cq = sv;  sq = -cv; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ang_r <= angles;
    end
    if (ld) begin
      x_r <= bbt_pkg::CORDIC_GAIN;
      y_r <= '0;
      z_r <= $signed({4'b0, aw[13:0], 16'b0});
    end else if (step) begin
      if (!z_r[bbt_pkg::XY_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - bbt_pkg::atan_turn(it_r);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + bbt_pkg::atan_turn(it_r);
      end
    end
    if (st) begin
      cs_r[axis_r] <= cq;
      sn_r[axis_r] <= sq;
    end
  end

  // Elementary rotations
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rxm[i][j] = (i == j) ? bbt_pkg::ROT_ONE : '0;
        rym[i][j] = (i == j) ? bbt_pkg::ROT_ONE : '0;
        rzm[i][j] = (i == j) ? bbt_pkg::ROT_ONE : '0;
      end
    end
    rxm[1][1] = bbt_pkg::ROT_W'(cs_r[0]);
    rxm[2][2] = bbt_pkg::ROT_W'(cs_r[0]);
    rxm[1][2] = bbt_pkg::ROT_W'(sn_r[0]);
    rxm[2][1] = -bbt_pkg::ROT_W'(sn_r[0]);
    rym[0][0] = bbt_pkg::ROT_W'(cs_r[1]);
    rym[2][2] = bbt_pkg::ROT_W'(cs_r[1]);
    rym[0][2] = -bbt_pkg::ROT_W'(sn_r[1]);
    rym[2][0] = bbt_pkg::ROT_W'(sn_r[1]);
    rzm[0][0] = bbt_pkg::ROT_W'(cs_r[2]);
    rzm[1][1] = bbt_pkg::ROT_W'(cs_r[2]);
    rzm[0][1] = bbt_pkg::ROT_W'(sn_r[2]);
    rzm[1][0] = -bbt_pkg::ROT_W'(sn_r[2]);
  end

  // Shared multiply-accumulate: first pass Rx*Ry, second pass (Rx*Ry)*Rz
  assign ma      = ph_r ? rxy_r[r_r][k_r] : rxm[r_r][k_r];
  assign mb      = ph_r ? rzm[k_r][c_r]   : rym[k_r][c_r];
  assign prod    = 40'(ma) * 40'(mb);
  assign acc_sum = acc_r + 42'(prod);
  assign wv      = bbt_pkg::ROT_W'(bbt_pkg::rnd16(66'(acc_sum)));

  always_ff @(posedge clk) begin
    if (st) begin
      acc_r <= '0;
    end else if (mac) begin
      acc_r <= (k_r == 2'd2) ? '0 : acc_sum;
    end
    if (mac && k_r == 2'd2 && !ph_r) begin
      rxy_r[r_r][c_r] <= wv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot_r[i][j] <= (i == j) ? bbt_pkg::ROT_ONE : '0;
        end
      end
    end else if (mac && k_r == 2'd2 && ph_r) begin
      rot_r[r_r][c_r] <= wv;
    end
  end

  assign busy  = (state_r != bbt_pkg::ROT_IDLE);
  assign rot_o = rot_r;

endmodule

// ===== hw/rtl/bbt_skid.sv =====
// ----------------------------------------------------------------------------
// bbt_skid
// Output register with a skid entry, so the pipeline keeps moving after the
// receiver stalls until the skid entry holds a word.
// ----------------------------------------------------------------------------
module bbt_skid #(
  parameter int W = bbt_pkg::OUT_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  input  logic [W-1:0] s_data,
  output logic         s_ready,
  output logic         m_valid,
  output logic [W-1:0] m_data,
  input  logic         m_ready
);

  logic         ov_r, ov_nxt;
  logic         sv_r, sv_nxt;
  logic [W-1:0] od_r;
  logic [W-1:0] sd_r;
  logic         ld_out, ld_skid, mv_skid;

  assign s_ready = !sv_r;

  always_comb begin
    ov_nxt  = ov_r;
    sv_nxt  = sv_r;
    ld_out  = 1'b0;
    ld_skid = 1'b0;
    mv_skid = 1'b0;
    if (m_ready || !ov_r) begin
      if (sv_r) begin
        mv_skid = 1'b1;
        ov_nxt  = 1'b1;
        sv_nxt  = 1'b0;
      end else begin
        ld_out = 1'b1;
        ov_nxt = s_valid;
      end
    end else if (s_valid && !sv_r) begin
      // hold the word that arrived while the output was stalled
      ld_skid = 1'b1;
      sv_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_skid) begin
      od_r <= sd_r;
    end else if (ld_out) begin
      od_r <= s_data;
    end
    if (ld_skid) begin
      sd_r <= s_data;
    end
  end

  assign m_valid = ov_r;
  assign m_data  = od_r;

endmodule

// ===== hw/rtl/bbox_placement_transform_top.sv =====
// ----------------------------------------------------------------------------
// bbox_placement_transform_top
// Bounding-box placement matrix T*Rx*Ry*Rz*S*C, Q16.16, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream: one bounding box per word (min x/y/z, max x/y/z).
//   out_* stream: one word per box, the top three rows of the 4x4 matrix.
//   cfg_* port  : register writes, taken at any edge with cfg_we high; write
//                 only while no box is in flight.
// Throughput is one box per cycle while in_tready is high. From input accept
// to out_tvalid a box passes the input register, which loads at the
// accepting edge, then a 33-stage divider (one quotient bit a stage), scale
// select, five multiply/round/sum stages and the output register.
// A write to the angle register starts the rotation setup (three CORDIC
// runs, then 54 multiply-accumulate steps): in_tready stays low while it
// runs. in_tready is also low in a cycle with cfg_we high.
// Reset clears the configuration registers, loads an identity rotation and
// empties the pipeline. When the receiver stalls, the skid entry takes one
// more word and then the whole pipeline holds; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bbox_placement_transform_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each, lowest first)
  input  logic [bbt_pkg::IN_W-1:0]          in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23 (32 bits each, lowest first)
  output logic [bbt_pkg::OUT_W-1:0]         out_tdata,
  input  logic                              cfg_we,
  input  logic [bbt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bbt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DL = bbt_pkg::DIV_LAT;

  // Configuration
  logic [2:0]  scale_mode_r;
  logic [1:0]  translate_mode_r;
  logic [62:0] scale_xyz_r;
  logic [62:0] translate_xyz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r     <= bbt_pkg::SM_NONE;
      translate_mode_r <= bbt_pkg::TM_CENTER;
      scale_xyz_r      <= '0;
      translate_xyz_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        bbt_pkg::CFG_SCALE_MODE:     scale_mode_r     <= cfg_wdata[2:0];
        bbt_pkg::CFG_TRANSLATE_MODE: translate_mode_r <= cfg_wdata[1:0];
        bbt_pkg::CFG_SCALE_XYZ:      scale_xyz_r      <= cfg_wdata;
        bbt_pkg::CFG_TRANSLATE_XYZ:  translate_xyz_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [20:0] sfld [3];
  logic signed [20:0] tfld [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sfld[i] = $signed(scale_xyz_r[21*i +: 21]);
      tfld[i] = $signed(translate_xyz_r[21*i +: 21]);
    end
  end

  // Rotation setup
  logic              rot_busy;
  bbt_pkg::rot_ent_t rot [3][3];

  bbt_rot u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_we && cfg_addr == bbt_pkg::CFG_ANGLES_XYZ),
    .angles (cfg_wdata[47:0]),
    .busy   (rot_busy),
    .rot_o  (rot)
  );

  // Pipeline control
  logic en;
  logic in_acc;

  assign in_tready = en && !rot_busy && !cfg_we;
  assign in_acc    = in_tvalid && in_tready;

  // Stage 1: input register
  logic               v1_r;
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= $signed(in_tdata[32*i +: 32]);
        hi_r[i] <= $signed(in_tdata[32*(i+3) +: 32]);
      end
    end
  end

  logic signed [31:0] ctr_c  [3];
  logic signed [20:0] dnum   [3];
  logic signed [32:0] dden   [3];
  always_comb begin
    logic signed [32:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum      = 33'(lo_r[i]) + 33'(hi_r[i]);
      ctr_c[i] = 32'(sum >>> 1);
      case (scale_mode_r)
        bbt_pkg::SM_MIN:    begin dnum[i] = sfld[0]; dden[i] = 33'(lo_r[i]); end
        bbt_pkg::SM_MAX:    begin dnum[i] = sfld[0]; dden[i] = 33'(hi_r[i]); end
        bbt_pkg::SM_EXTENT: begin
          dnum[i] = sfld[i];
          dden[i] = 33'(hi_r[i]) - 33'(lo_r[i]);
        end
        default:            begin dnum[i] = '0; dden[i] = '0; end
      endcase
    end
  end

  // Dividers, with the center carried alongside
  logic               dv;
  logic signed [31:0] quo [3];
  logic signed [31:0] ctr_d_r [DL][3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_div
    if (gi == 0) begin : g_first
      bbt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_r),
        .num       (dnum[gi]),
        .den       (dden[gi]),
        .out_valid (dv),
        .quo       (quo[gi])
      );
    end else begin : g_rest
      bbt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_r),
        .num       (dnum[gi]),
        .den       (dden[gi]),
        .out_valid (),
        .quo       (quo[gi])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctr_d_r[0] <= ctr_c;
      for (int j = 1; j < DL; j++) begin
        ctr_d_r[j] <= ctr_d_r[j-1];
      end
    end
  end

  // Stage S: scale vector
  logic               vs_r;
  logic signed [31:0] sc_r   [3];
  logic signed [31:0] ctrs_r [3];
  logic signed [31:0] sc_c   [3];
  always_comb begin
    logic signed [31:0] f;
    f = quo[0];
    if (scale_mode_r == bbt_pkg::SM_MIN) begin
      if (quo[1] < f) f = quo[1];
      if (quo[2] < f) f = quo[2];
    end else begin
      if (quo[1] > f) f = quo[1];
      if (quo[2] > f) f = quo[2];
    end
    for (int i = 0; i < 3; i++) begin
      case (scale_mode_r)
        bbt_pkg::SM_MIN,
        bbt_pkg::SM_MAX:    sc_c[i] = f;
        bbt_pkg::SM_REL:    sc_c[i] = 32'(sfld[i]) <<< 8;
        bbt_pkg::SM_EXTENT: sc_c[i] = quo[i];
        default:            sc_c[i] = bbt_pkg::Q_ONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r   <= sc_c;
      ctrs_r <= ctr_d_r[DL-1];
    end
  end

  // M1: R*s and center*s products
  logic               vm1_r;
  logic signed [51:0] pm_r  [3][3];
  logic signed [63:0] pu_r  [3];
  logic signed [31:0] ctr1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pm_r[r][c] <= 52'(rot[r][c]) * 52'(sc_r[c]);
        end
        pu_r[r] <= 64'(ctrs_r[r]) * 64'(sc_r[r]);
      end
      ctr1_r <= ctrs_r;
    end
  end

  // M2: round and saturate
  logic               vm2_r;
  logic signed [31:0] m2_r  [3][3];
  logic signed [31:0] u_r   [3];
  logic signed [31:0] ctr2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m2_r[r][c] <= bbt_pkg::sat32(bbt_pkg::rnd16(66'(pm_r[r][c])));
        end
        u_r[r] <= bbt_pkg::sat32(bbt_pkg::rnd16(-66'(pu_r[r])));
      end
      ctr2_r <= ctr1_r;
    end
  end

  // M3: R*u products
  logic               vm3_r;
  logic signed [51:0] pa_r  [3][3];
  logic signed [31:0] m3_r  [3][3];
  logic signed [31:0] ctr3_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pa_r[r][c] <= 52'(rot[r][c]) * 52'(u_r[c]);
        end
      end
      m3_r   <= m2_r;
      ctr3_r <= ctr2_r;
    end
  end

  // M4: row sums and translation term
  logic               vm4_r;
  logic signed [53:0] acc_r [3];
  logic signed [33:0] tr_r  [3];
  logic signed [31:0] m4_r  [3][3];
  logic signed [33:0] tr_c  [3];

  always_comb begin
    logic signed [33:0] tv;
    for (int r = 0; r < 3; r++) begin
      tv = 34'(tfld[r]) <<< 8;
      case (translate_mode_r)
        bbt_pkg::TM_OFFSET: tr_c[r] = tv + 34'(ctr3_r[r]);
        bbt_pkg::TM_ABS:    tr_c[r] = tv;
        default:            tr_c[r] = 34'(ctr3_r[r]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        acc_r[r] <= 54'(pa_r[r][0]) + 54'(pa_r[r][1]) + 54'(pa_r[r][2]);
      end
      tr_r <= tr_c;
      m4_r <= m3_r;
    end
  end

  // M5: final word
  logic                      vm5_r;
  logic [bbt_pkg::OUT_W-1:0] o_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          o_r[32*(4*r+c) +: 32] <= m4_r[r][c];
        end
        o_r[32*(4*r+3) +: 32] <=
          bbt_pkg::sat32(66'(tr_r[r]) + bbt_pkg::rnd16(66'(acc_r[r])));
      end
    end
  end

  // Valid bits travel with the data and hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vs_r  <= 1'b0;
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vm3_r <= 1'b0;
      vm4_r <= 1'b0;
      vm5_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_acc;
      vs_r  <= dv;
      vm1_r <= vs_r;
      vm2_r <= vm1_r;
      vm3_r <= vm2_r;
      vm4_r <= vm3_r;
      vm5_r <= vm4_r;
    end
  end

  bbt_skid #(.W(bbt_pkg::OUT_W)) u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (vm5_r),
    .s_data  (o_r),
    .s_ready (en),
    .m_valid (out_tvalid),
    .m_data  (out_tdata),
    .m_ready (out_tready)
  );

endmodule

// ===== hw/rtl/bbt_chk.sv =====
// ----------------------------------------------------------------------------
// bbt_chk
// Port-level checks for the placement transform, bound to the top level.
// ----------------------------------------------------------------------------
module bbt_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bbt_pkg::OUT_W-1:0]      out_tdata,
  input logic                           cfg_we,
  input logic [bbt_pkg::CFG_ADDR_W-1:0] cfg_addr
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out word changed while stalled");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // no box taken in a register-write cycle
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_tready)
    else $error("in_tready high during a register write");

  // angle write starts the rotation setup, input closed
  a_rot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_addr == bbt_pkg::CFG_ANGLES_XYZ |=> !in_tready ##1 !in_tready)
    else $error("input open during rotation setup");

endmodule

bind bbox_placement_transform_top bbt_chk u_bbt_chk (.*);
